// ===== sv/okvt_pkg.sv =====
// Shared operation codes and chain link type for the ordered key/value table.
package okvt_pkg;

  localparam int PosW    = 8;
  localparam int PosSpan = 1 << PosW;
  localparam int OpW     = 3;

  typedef logic [OpW-1:0] op_t;

  localparam op_t OpInsert = 3'd0;
  localparam op_t OpUpdate = 3'd1;
  localparam op_t OpUpsert = 3'd2;
  localparam op_t OpErase  = 3'd3;
  localparam op_t OpLookup = 3'd4;
  localparam op_t OpRead   = 3'd5;

  // Token that walks the cell chain with one request.
  typedef struct packed {
    logic active;  // token sits at this hop
    logic hit;     // key matched an occupied cell, or index read done
    logic wrote;   // a new pair was placed
  } link_t;

endpackage

// ===== sv/okvt_cell.sv =====
// One table entry: stores a pair, compares it against the request and shifts on erase.
module okvt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int INDEX      = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  okvt_pkg::op_t                 op_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [VALUE_BITS-1:0]         val_i,
  input  logic [okvt_pkg::PosW-1:0]     pos_i,
  input  okvt_pkg::link_t               link_i,
  input  logic [KEY_BITS-1:0]           rkey_i,
  input  logic [VALUE_BITS-1:0]         rval_i,
  output okvt_pkg::link_t               link_o,
  output logic [KEY_BITS-1:0]           rkey_o,
  output logic [VALUE_BITS-1:0]         rval_o,
  input  logic                          nxt_occ_i,
  input  logic [KEY_BITS-1:0]           nxt_key_i,
  input  logic [VALUE_BITS-1:0]         nxt_val_i,
  output logic                          occ_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [VALUE_BITS-1:0]         val_o
);
  import okvt_pkg::*;

  logic                  occ_q, occ_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  link_t                 link_q, link_d;
  logic [KEY_BITS-1:0]   rkey_q, rkey_d;
  logic [VALUE_BITS-1:0] rval_q, rval_d;

  logic match, pos_hit, free_slot;

  assign match     = occ_q && (key_q == key_i);
  assign pos_hit   = occ_q && (INDEX < PosSpan) && (pos_i == PosW'(INDEX));
  // first empty cell after all occupied ones, and the key was not seen
  assign free_slot = !occ_q && !link_i.hit && !link_i.wrote;

  always_comb begin
    occ_d  = occ_q;
    key_d  = key_q;
    val_d  = val_q;
    link_d = link_i;
    rkey_d = rkey_i;
    rval_d = rval_i;
    if (link_i.active) begin
      unique case (op_i)
        OpInsert: begin
          if (match) begin
            link_d.hit = 1'b1;
          end else if (free_slot) begin
            occ_d        = 1'b1;
            key_d        = key_i;
            val_d        = val_i;
            link_d.wrote = 1'b1;
          end
        end
        OpUpdate: begin
          if (match) begin
            val_d      = val_i;
            link_d.hit = 1'b1;
          end
        end
        OpUpsert: begin
          if (match) begin
            val_d      = val_i;
            link_d.hit = 1'b1;
          end else if (free_slot) begin
            occ_d        = 1'b1;
            key_d        = key_i;
            val_d        = val_i;
            link_d.wrote = 1'b1;
          end
        end
        OpErase: begin
          // pull the neighbor down from the matching cell onward
          link_d.hit = link_i.hit | match;
          if (occ_q && (link_i.hit || match)) begin
            occ_d = nxt_occ_i;
            key_d = nxt_key_i;
            val_d = nxt_val_i;
          end
        end
        OpLookup: begin
          if (match) begin
            rval_d     = val_q;
            link_d.hit = 1'b1;
          end
        end
        OpRead: begin
          if (pos_hit) begin
            rkey_d     = key_q;
            rval_d     = val_q;
            link_d.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      link_q <= '0;
    end else begin
      occ_q  <= occ_d;
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    rkey_q <= rkey_d;
    rval_q <= rval_d;
  end

  assign link_o = link_q;
  assign rkey_o = rkey_q;
  assign rval_o = rval_q;
  assign occ_o  = occ_q;
  assign key_o  = key_q;
  assign val_o  = val_q;

endmodule

// ===== sv/ordered_key_value_table.sv =====
// Top level of the ordered key/value table: request intake, cell chain, count and result.
//
// The table is a row of CAPACITY cells, each holding one pair; occupied cells are
// always packed from position 0. A request is held at the top and broadcast to all
// cells while a token walks down the row one cell per clock, carrying the found and
// inserted flags and the captured key/value; erase shifts later entries down as the
// token passes. A word's result is offered once the token has walked over the whole
// row; no new word is taken while one is still walking. A new word is accepted the
// cycle after the previous result is placed in the output register, even while that
// result still waits to be taken. No clearing pass after reset is needed.
module ordered_key_value_table #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] key_in_i,
  input  logic [31:0] value_in_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        success_o,
  output logic [31:0] key_out_o,
  output logic [31:0] value_out_o,
  output logic [8:0]  pair_count_o
);
  import okvt_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  // request held for the walk
  op_t                   req_op_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic [PosW-1:0]       req_pos_q;

  logic busy_q, start_q, hold_q, out_valid_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  link_t                 link [0:CAPACITY];
  logic [KEY_BITS-1:0]   rkey [0:CAPACITY];
  logic [VALUE_BITS-1:0] rval [0:CAPACITY];
  logic                  occ  [0:CAPACITY];
  logic [KEY_BITS-1:0]   ckey [0:CAPACITY];
  logic [VALUE_BITS-1:0] cval [0:CAPACITY];

  logic in_accept, tail, out_free, load_tail, load_hold, res_ok;

  logic        hold_ok_q;
  logic [31:0] hold_key_q, hold_val_q;
  logic [8:0]  hold_cnt_q;
  logic        out_ok_q;
  logic [31:0] out_key_q, out_val_q;
  logic [8:0]  out_cnt_q;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;

  assign link[0] = '{active: start_q, hit: 1'b0, wrote: 1'b0};
  assign rkey[0] = '0;
  assign rval[0] = '0;
  // past the last cell there is nothing to pull down
  assign occ[CAPACITY]  = 1'b0;
  assign ckey[CAPACITY] = '0;
  assign cval[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    okvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (req_op_q),
      .key_i     (req_key_q),
      .val_i     (req_val_q),
      .pos_i     (req_pos_q),
      .link_i    (link[i]),
      .rkey_i    (rkey[i]),
      .rval_i    (rval[i]),
      .link_o    (link[i+1]),
      .rkey_o    (rkey[i+1]),
      .rval_o    (rval[i+1]),
      .nxt_occ_i (occ[i+1]),
      .nxt_key_i (ckey[i+1]),
      .nxt_val_i (cval[i+1]),
      .occ_o     (occ[i]),
      .key_o     (ckey[i]),
      .val_o     (cval[i])
    );
  end

  assign tail     = link[CAPACITY].active;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_tail = tail && out_free;
  assign load_hold = !tail && hold_q && out_free;

  always_comb begin
    unique case (req_op_q) inside
      OpInsert:                           res_ok = link[CAPACITY].wrote;
      OpUpsert:                           res_ok = link[CAPACITY].hit | link[CAPACITY].wrote;
      OpUpdate, OpErase, OpLookup, OpRead: res_ok = link[CAPACITY].hit;
      default:                            res_ok = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (link[CAPACITY].wrote) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (req_op_q == OpErase && link[CAPACITY].hit) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      start_q <= in_accept;
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (load_tail || load_hold) begin
        busy_q <= 1'b0;
      end
      if (tail) begin
        cnt_q <= cnt_d;
      end
      // park the result while the output register is still taken
      if (tail && !out_free) begin
        hold_q <= 1'b1;
      end else if (load_hold) begin
        hold_q <= 1'b0;
      end
      if (load_tail || load_hold) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q  <= operation_i;
      req_key_q <= KEY_BITS'(key_in_i);
      req_val_q <= VALUE_BITS'(value_in_i);
      req_pos_q <= position_i;
    end
    if (tail && !out_free) begin
      hold_ok_q  <= res_ok;
      hold_key_q <= 32'(rkey[CAPACITY]);
      hold_val_q <= 32'(rval[CAPACITY]);
      hold_cnt_q <= 9'(cnt_d);
    end
    if (load_tail) begin
      out_ok_q  <= res_ok;
      out_key_q <= 32'(rkey[CAPACITY]);
      out_val_q <= 32'(rval[CAPACITY]);
      out_cnt_q <= 9'(cnt_d);
    end else if (load_hold) begin
      out_ok_q  <= hold_ok_q;
      out_key_q <= hold_key_q;
      out_val_q <= hold_val_q;
      out_cnt_q <= hold_cnt_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign success_o    = out_ok_q;
  assign key_out_o    = out_key_q;
  assign value_out_o  = out_val_q;
  assign pair_count_o = out_cnt_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the ordered key/value table: directed and random requests.
module testbench;
  import okvt_pkg::*;

  localparam int  Capacity = 256;
  localparam op_t OpBadLo  = 3'd6;
  localparam op_t OpBadHi  = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [31:0] key;
    logic [31:0] value;
    logic [8:0]  count;
  } table_reply_t;

  // Shadow copy of the table; predicts one reply per accepted request word.
  class kv_table_scoreboard;
    bit [31:0]    keys   [Capacity];
    bit [31:0]    values [Capacity];
    int           count;
    int           peak;
    int           full_refusals;
    int           checked;
    int           errors;
    table_reply_t replies_due [$];

    function int find_key(bit [31:0] key);
      for (int i = 0; i < count; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    function bit put_value(bit [31:0] key, bit [31:0] value);
      int p;
      p = find_key(key);
      if (p < 0) return 1'b0;
      values[p] = value;
      return 1'b1;
    endfunction

    function bit add_pair(bit [31:0] key, bit [31:0] value);
      if (count >= Capacity) begin
        full_refusals++;
        return 1'b0;
      end
      if (find_key(key) >= 0) return 1'b0;
      keys[count]   = key;
      values[count] = value;
      count++;
      if (count > peak) peak = count;
      return 1'b1;
    endfunction

    function void note_request(op_t op, bit [31:0] key, bit [31:0] value, bit [7:0] pos);
      table_reply_t r;
      int           p;
      r = '0;
      case (op)
        OpInsert: r.ok = add_pair(key, value);
        OpUpdate: r.ok = put_value(key, value);
        OpUpsert: r.ok = put_value(key, value) || add_pair(key, value);
        OpErase: begin
          p = find_key(key);
          if (p >= 0) begin
            // close the gap behind the erased pair
            for (int i = p; i + 1 < count; i++) begin
              keys[i]   = keys[i+1];
              values[i] = values[i+1];
            end
            count--;
            r.ok = 1'b1;
          end
        end
        OpLookup: begin
          p = find_key(key);
          if (p >= 0) begin
            r.ok    = 1'b1;
            r.value = values[p];
          end
        end
        OpRead: begin
          if (int'(pos) < count) begin
            r.ok    = 1'b1;
            r.key   = keys[pos];
            r.value = values[pos];
          end
        end
        default: ;
      endcase
      r.count = count[8:0];
      replies_due.push_back(r);
    endfunction

    function void check_result(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing expected: ok %0b key %h value %h count %0d",
                 $time, got.ok, got.key, got.value, got.count);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got.ok !== want.ok) begin
        $display("%0t: success expected %0b actual %0b", $time, want.ok, got.ok);
        errors++;
      end
      if (got.key !== want.key) begin
        $display("%0t: key_out expected %h actual %h", $time, want.key, got.key);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value_out expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: pair_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [31:0] key_in_i;
  logic [31:0] value_in_i;
  logic [7:0]  position_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        success_o;
  logic [31:0] key_out_o;
  logic [31:0] value_out_o;
  logic [8:0]  pair_count_o;

  kv_table_scoreboard sb;
  bit                 quiet;
  int                 sent;

  ordered_key_value_table #(
    .CAPACITY  (Capacity),
    .KEY_BITS  (32),
    .VALUE_BITS(32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_in_i    (key_in_i),
    .value_in_i  (value_in_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .success_o   (success_o),
    .key_out_o   (key_out_o),
    .value_out_o (value_out_o),
    .pair_count_o(pair_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 1) return $urandom_range(300, 20);
    if (r < 24) return $urandom_range(4, 1);
    return 0;
  endfunction

  function automatic op_t pick_op(int w_ins, int w_upd, int w_ups, int w_era, int w_lkp,
                                  int w_rd);
    int r;
    r = $urandom_range(99);
    if (r < w_ins) return OpInsert;
    r -= w_ins;
    if (r < w_upd) return OpUpdate;
    r -= w_upd;
    if (r < w_ups) return OpUpsert;
    r -= w_ups;
    if (r < w_era) return OpErase;
    r -= w_era;
    if (r < w_lkp) return OpLookup;
    r -= w_lkp;
    if (r < w_rd) return OpRead;
    return $urandom_range(1) ? OpBadHi : OpBadLo;
  endfunction

  function automatic bit [31:0] pick_key(int fresh_pct);
    int r;
    r = $urandom_range(99);
    if (r < fresh_pct) return $urandom;
    if (r < fresh_pct + 5) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    if (sb.count > 0) return sb.keys[$urandom_range(sb.count - 1)];
    return $urandom;
  endfunction

  function automatic bit [7:0] pick_position();
    int p;
    if ($urandom_range(99) < 70) begin
      p = $urandom_range(sb.count);
      if (p > 255) p = 255;
      return p[7:0];
    end
    return 8'($urandom_range(255));
  endfunction

  // Offer one request word after a random gap; hold it until taken.
  task automatic push_request(op_t op, bit [31:0] key, bit [31:0] value, bit [7:0] pos);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    operation_i = op;
    key_in_i    = key;
    value_in_i  = value;
    position_i  = pos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, key, value, pos);
    sent++;
  endtask

  task automatic push_random(op_t op, int fresh_pct);
    bit [31:0] key;
    bit [31:0] value;
    bit [7:0]  pos;
    key   = pick_key(fresh_pct);
    value = $urandom;
    pos   = pick_position();
    push_request(op, key, value, pos);
  endtask

  // Result side: random stalls, occasional long holds, none while quiet.
  initial begin
    int hold;
    int r;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        hold = 0;
        out_stall_i = 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 1) hold = $urandom_range(300, 20);
        out_stall_i = (r < 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({success_o, key_out_o, value_out_o, pair_count_o});
  end

  initial begin
    sb          = new();
    quiet       = 1'b0;
    sent        = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OpInsert;
    key_in_i    = '0;
    value_in_i  = '0;
    position_i  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: every search misses; then insert, update, upsert, look up and read back
    push_request(OpRead,   32'h0,         32'h0,         8'd0);
    push_request(OpLookup, 32'h0,         32'h0,         8'd0);
    push_request(OpErase,  32'h0,         32'h0,         8'd0);
    push_request(OpUpdate, 32'h0,         32'h1,         8'd0);
    push_request(OpInsert, 32'h0,         32'hFFFF_FFFF, 8'd0);
    push_request(OpInsert, 32'hFFFF_FFFF, 32'h0,         8'd0);
    push_request(OpInsert, 32'h0,         32'h1234_5678, 8'd0);
    push_request(OpInsert, 32'h1234_5678, 32'hA5A5_A5A5, 8'd0);
    push_request(OpUpdate, 32'h0,         32'h5A5A_5A5A, 8'd0);
    push_request(OpUpsert, 32'hFFFF_FFFF, 32'h1357_9BDF, 8'd0);
    push_request(OpUpsert, 32'h8000_0001, 32'h2468_ACE0, 8'd0);
    push_request(OpLookup, 32'h1234_5678, 32'h0,         8'd0);
    push_request(OpLookup, 32'hDEAD_BEEF, 32'h0,         8'd0);
    push_request(OpRead,   32'h0,         32'h0,         8'd0);
    push_request(OpRead,   32'h0,         32'h0,         8'd3);
    push_request(OpRead,   32'h0,         32'h0,         8'd4);
    push_request(OpRead,   32'h0,         32'h0,         8'd255);
    // erase at the front, then at the back
    push_request(OpErase,  32'h0,         32'h0,         8'd0);
    push_request(OpRead,   32'h0,         32'h0,         8'd0);
    push_request(OpErase,  32'h8000_0001, 32'h0,         8'd0);
    push_request(OpErase,  32'h8000_0001, 32'h0,         8'd0);
    push_request(OpBadLo,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    push_request(OpBadHi,  32'h0,         32'h0,         8'd0);
    push_request(OpLookup, 32'hFFFF_FFFF, 32'h0,         8'd0);

    // mixed traffic on a small table, both sides at full rate
    quiet = 1'b1;
    repeat (80) push_random(pick_op(20, 15, 15, 15, 15, 15), 30);
    quiet = 1'b0;

    // grow to capacity
    while (sb.count < Capacity) push_random(pick_op(55, 0, 30, 3, 5, 5), 90);
    // work against the full table
    repeat (40) push_random(pick_op(25, 10, 15, 10, 20, 18), 50);
    // drain mostly through erase
    repeat (60) push_random(pick_op(5, 5, 5, 70, 7, 6), 5);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Capacity + 10) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d replies; table peaked at %0d pairs,",
             sent, sb.checked, sb.peak);
    $display("with %0d inserts refused on a full table.", sb.full_refusals);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/okvt_pkg.sv
sv/okvt_cell.sv
sv/ordered_key_value_table.sv
tb/sv/testbench.sv
